@@ src/four_level_strict_priority_queue_unit_assert.svh @@
// Assertion macros for the strict-priority queue checker.
`ifndef FOUR_LEVEL_STRICT_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define FOUR_LEVEL_STRICT_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fpq_pkg.sv @@
`timescale 1ns / 1ps
package fpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int LEVELS      = 4;
    localparam int ID_W        = 16;
    localparam int LVL_W       = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = $clog2(LEVELS * QUEUE_DEPTH);
    localparam int MEM_DEPTH   = LEVELS * QUEUE_DEPTH;

    localparam logic [2:0] RC_QUEUED    = 3'd0;
    localparam logic [2:0] RC_ALREADY   = 3'd1;
    localparam logic [2:0] RC_NO_CLASS  = 3'd2;
    localparam logic [2:0] RC_NOT_VALID = 3'd3;
    localparam logic [2:0] RC_DEQUEUED  = 3'd4;
    localparam logic [2:0] RC_EMPTY     = 3'd5;
    localparam logic [2:0] RC_FULL      = 3'd6;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    localparam logic [1:0] ST_NORMAL    = 2'd0;
    localparam logic [1:0] ST_NOT_VALID = 2'd1;
    localparam logic [1:0] ST_DEMOTED   = 2'd2;

    localparam logic [3:0] CLASS_ONE   = 4'd1;
    localparam logic [3:0] CLASS_TWO   = 4'd2;
    localparam logic [3:0] CLASS_THREE = 4'd3;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_id;
    } fpq_cmd_t;

    typedef struct packed {
        logic deq_hit;
    } fpq_sts_t;

    function automatic logic [LVL_W-1:0] level_of(input logic [3:0] cls,
                                                  input logic [1:0] st);
        logic [LVL_W-1:0] lv;
        lv = LVL_W'(3);
        if (st != ST_DEMOTED)
        begin
            case (cls)
                CLASS_ONE:   lv = LVL_W'(0);
                CLASS_TWO:   lv = LVL_W'(1);
                CLASS_THREE: lv = LVL_W'(2);
                default:     lv = LVL_W'(3);
            endcase
        end
        return lv;
    endfunction

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            n = '0;
        else
            n = p + PTR_W'(1);
        return n;
    endfunction

endpackage

@@ src/fpq_ctrl.sv @@
`timescale 1ns / 1ps
module fpq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  fpq_pkg::fpq_sts_t sts,
    output fpq_pkg::fpq_cmd_t cmd
);
    import fpq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec = 1'b1;
                    if (sts.deq_hit)
                        state_next = S_READ;
                    else
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_READ:
            begin
                // output register was drained when the read was issued
                cmd.load_id    = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/fpq_datapath.sv @@
`timescale 1ns / 1ps
module fpq_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fpq_pkg::fpq_cmd_t          cmd,
    output fpq_pkg::fpq_sts_t          sts,
    input  logic                       kind,
    input  logic [fpq_pkg::ID_W-1:0]   entry_id,
    input  logic [3:0]                 class_value,
    input  logic                       has_class,
    input  logic                       already_queued,
    input  logic [1:0]                 entry_status,
    input  logic                       has_request,
    output logic [2:0]                 result_code,
    output logic [fpq_pkg::ID_W-1:0]   out_id,
    output logic [fpq_pkg::LVL_W-1:0]  out_level,
    output logic                       clear_request
);
    import fpq_pkg::*;

    // captured item
    logic              kind_reg;
    logic [ID_W-1:0]   id_reg;
    logic [3:0]        class_reg;
    logic              has_class_reg;
    logic              already_reg;
    logic [1:0]        status_reg;
    logic              request_reg;

    logic [PTR_W-1:0]  head_reg [LEVELS];
    logic [PTR_W-1:0]  head_next [LEVELS];
    logic [PTR_W-1:0]  tail_reg [LEVELS];
    logic [PTR_W-1:0]  tail_next [LEVELS];
    logic [CNT_W-1:0]  cnt_reg [LEVELS];
    logic [CNT_W-1:0]  cnt_next [LEVELS];

    logic [ID_W-1:0]   mem [MEM_DEPTH];
    logic [ID_W-1:0]   rd_data_reg;

    logic [2:0]        code_reg;
    logic [ID_W-1:0]   res_id_reg;
    logic [LVL_W-1:0]  level_reg;
    logic              clear_reg;

    logic [LEVELS-1:0] nonempty;
    logic [LVL_W-1:0]  deq_lv;
    logic [LVL_W-1:0]  enq_lv;
    logic [LVL_W-1:0]  sel_lv;
    logic [PTR_W-1:0]  sel_ptr;
    logic [ADDR_W-1:0] addr;
    logic              full;
    logic [2:0]        rc;
    logic [LVL_W-1:0]  rlv;
    logic              rclr;
    logic              do_write;
    logic              do_read;

    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
            nonempty[l] = (cnt_reg[l] != '0);
        deq_lv = LVL_W'(LEVELS - 1);
        for (int l = LEVELS - 1; l >= 0; l--)
            if (nonempty[l])
                deq_lv = LVL_W'(l);
    end

    assign enq_lv  = level_of(class_reg, status_reg);
    assign sel_lv  = (kind_reg == KIND_DEQ) ? deq_lv : enq_lv;
    assign sel_ptr = (kind_reg == KIND_DEQ) ? head_reg[sel_lv] : tail_reg[sel_lv];
    assign full    = (cnt_reg[sel_lv] == CNT_W'(QUEUE_DEPTH));
    assign addr    = ADDR_W'(sel_lv) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(sel_ptr);

    always_comb
    begin
        rc   = RC_QUEUED;
        rlv  = '0;
        rclr = 1'b0;
        if (kind_reg == KIND_DEQ)
        begin
            if (|nonempty)
            begin
                rc  = RC_DEQUEUED;
                rlv = deq_lv;
            end
            else
                rc = RC_EMPTY;
        end
        else if (already_reg)
            rc = RC_ALREADY;
        else if (!has_class_reg)
            rc = RC_NO_CLASS;
        else if (status_reg == ST_NOT_VALID)
            rc = RC_NOT_VALID;
        else if (full)
        begin
            rc  = RC_FULL;
            rlv = enq_lv;
        end
        else
        begin
            rc   = RC_QUEUED;
            rlv  = enq_lv;
            rclr = request_reg;
        end
    end

    assign do_write    = (kind_reg == KIND_ENQ) && (rc == RC_QUEUED);
    assign do_read     = (kind_reg == KIND_DEQ) && (|nonempty);
    assign sts.deq_hit = do_read;

    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            head_next[l] = head_reg[l];
            tail_next[l] = tail_reg[l];
            cnt_next[l]  = cnt_reg[l];
        end
        if (cmd.exec && do_write)
        begin
            tail_next[sel_lv] = advance(tail_reg[sel_lv]);
            cnt_next[sel_lv]  = cnt_reg[sel_lv] + CNT_W'(1);
        end
        if (cmd.exec && do_read)
        begin
            head_next[sel_lv] = advance(head_reg[sel_lv]);
            cnt_next[sel_lv]  = cnt_reg[sel_lv] - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
        end
        else
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l] <= head_next[l];
                tail_reg[l] <= tail_next[l];
                cnt_reg[l]  <= cnt_next[l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && do_write)
            mem[addr] <= id_reg;
        if (cmd.exec)
            rd_data_reg <= mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg      <= kind;
            id_reg        <= entry_id;
            class_reg     <= class_value;
            has_class_reg <= has_class;
            already_reg   <= already_queued;
            status_reg    <= entry_status;
            request_reg   <= has_request;
        end
        if (cmd.exec)
        begin
            code_reg   <= rc;
            level_reg  <= rlv;
            clear_reg  <= rclr;
            res_id_reg <= '0;
        end
        if (cmd.load_id)
            res_id_reg <= rd_data_reg;
    end

    assign result_code   = code_reg;
    assign out_id        = res_id_reg;
    assign out_level     = level_reg;
    assign clear_request = clear_reg;

endmodule

@@ src/four_level_strict_priority_queue_unit.sv @@
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in        in_valid / in_ready    kind, entry_id, class_value, has_class,
//                                  already_queued, entry_status, has_request
// out       out_valid / out_ready  result_code, out_id, out_level, clear_request
//
// One item at a time. Enqueue and empty dequeue pass through the IDLE and EXEC
// states, accept to accept. Dequeue of an entry adds the READ state for the
// registered read of the shared identifier memory.
// The item executes only once the output register is free, so a stalled
// result holds the next item; a new item is accepted while a result waits.
// Reset clears pointers and counts; the identifier memory is not cleared.
module four_level_strict_priority_queue_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       kind,
    input  logic [fpq_pkg::ID_W-1:0]   entry_id,
    input  logic [3:0]                 class_value,
    input  logic                       has_class,
    input  logic                       already_queued,
    input  logic [1:0]                 entry_status,
    input  logic                       has_request,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 result_code,
    output logic [fpq_pkg::ID_W-1:0]   out_id,
    output logic [fpq_pkg::LVL_W-1:0]  out_level,
    output logic                       clear_request
);
    import fpq_pkg::*;

    fpq_cmd_t cmd;
    fpq_sts_t sts;

    fpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fpq_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .kind           (kind),
        .entry_id       (entry_id),
        .class_value    (class_value),
        .has_class      (has_class),
        .already_queued (already_queued),
        .entry_status   (entry_status),
        .has_request    (has_request),
        .result_code    (result_code),
        .out_id         (out_id),
        .out_level      (out_level),
        .clear_request  (clear_request)
    );

endmodule

@@ src/fpq_checker.sv @@
`timescale 1ns / 1ps
`include "four_level_strict_priority_queue_unit_assert.svh"
module fpq_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [2:0]                 result_code,
    input logic [fpq_pkg::ID_W-1:0]   out_id,
    input logic [fpq_pkg::LVL_W-1:0]  out_level,
    input logic                       clear_request
);
    import fpq_pkg::*;

    `FPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_code) && $stable(out_id), "result item changed while stalled")
    `FPQ_ASSERT_NOW(a_id_only_deq, out_valid && (result_code != RC_DEQUEUED), out_id == '0, "nonzero id on a non-dequeue result")
    `FPQ_ASSERT_NOW(a_clear_only_queued, out_valid && clear_request, result_code == RC_QUEUED, "request cleared without a queued result")
    `FPQ_ASSERT_NOW(a_level_zero, out_valid && (result_code == RC_ALREADY || result_code == RC_NO_CLASS || result_code == RC_NOT_VALID || result_code == RC_EMPTY), out_level == '0, "level set on a rejected or empty result")

endmodule

bind four_level_strict_priority_queue_unit fpq_checker u_fpq_checker (.*);
